// File: hdl/triangle_aabb_overlap_test_defines.svh
// assertion macros for the triangle versus box overlap block
// included by the checker module, no other dependencies
`ifndef TRIANGLE_AABB_OVERLAP_TEST_DEFINES_SVH
`define TRIANGLE_AABB_OVERLAP_TEST_DEFINES_SVH

// clocked assertion, masked while reset is asserted
`define TAO_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tao check failed");

// clocked assertion that is also checked during reset
`define TAO_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) (prop)) else $error("tao reset check failed");

`endif

// File: hdl/tao_pkg.sv
// shared widths, types and helpers for the triangle versus box overlap block
// no dependencies
`default_nettype none

package tao_pkg;

  localparam int CW   = 32;              // coordinate width
  localparam int VW   = CW + 2;          // doubled relative vertex
  localparam int HW   = CW + 1;          // doubled half size
  localparam int EW   = CW + 3;          // triangle edge
  localparam int PW   = VW + EW;         // vertex times edge product
  localparam int PJW  = PW + 1;          // edge axis projection
  localparam int RW   = HW + EW + 2;     // edge axis radius
  localparam int NPW  = 2 * EW;          // edge times edge product
  localparam int NW   = NPW + 1;         // normal component
  localparam int NL   = (NW + 1) / 2;    // low split of a normal component
  localparam int NH   = NW - NL;         // high split of a normal component
  localparam int DW   = NW + VW + 3;     // normal dot product and compare width
  localparam int NREG = 6;
  localparam int IDXW = 3;

  localparam logic [IDXW-1:0] REG_MIN_X = 3'd0;
  localparam logic [IDXW-1:0] REG_MIN_Y = 3'd1;
  localparam logic [IDXW-1:0] REG_MIN_Z = 3'd2;
  localparam logic [IDXW-1:0] REG_MAX_X = 3'd3;
  localparam logic [IDXW-1:0] REG_MAX_Y = 3'd4;
  localparam logic [IDXW-1:0] REG_MAX_Z = 3'd5;

  typedef logic signed [CW-1:0]  coord_t;
  typedef logic signed [VW-1:0]  v_t;
  typedef logic signed [HW-1:0]  h_t;
  typedef logic signed [EW-1:0]  e_t;
  typedef logic signed [PJW-1:0] pj_t;
  typedef logic signed [RW-1:0]  r_t;
  typedef logic signed [NW-1:0]  n_t;
  typedef logic signed [DW-1:0]  sw_t;

  // after stage two: vertices, edges, half sizes, box axis verdict
  typedef struct packed {
    logic                vld;
    logic                sep;
    v_t [2:0][2:0]       v;
    e_t [2:0][2:0]       e;
    h_t [2:0]            h;
  } front_t;

  // after stage four: normal, edge axis projections and radii, first vertex, half sizes
  typedef struct packed {
    logic                vld;
    logic                sep;
    v_t [2:0]            v0;
    h_t [2:0]            h;
    n_t [2:0]            n;
    pj_t [2:0][2:0][2:0] pj;
    r_t [2:0][2:0]       rad;
  } prod_t;

  // true when the interval of p0..p2 lies strictly outside [-r, r]
  function automatic logic sep3(input sw_t p0, input sw_t p1, input sw_t p2, input sw_t r);
    sw_t hi;
    sw_t lo;
    hi = p0;
    lo = p0;
    if (hi < p1) hi = p1;
    if (hi < p2) hi = p2;
    if (p1 < lo) lo = p1;
    if (p2 < lo) lo = p2;
    return (hi < -r) || (r < lo);
  endfunction

endpackage

`default_nettype wire

// File: hdl/tao_ifs.sv
// valid/ready channel interfaces for triangles in and overlap flags out
// depends on tao_pkg
`default_nettype none

interface tao_in_if;
  logic            valid;
  logic            ready;
  tao_pkg::coord_t a_x, a_y, a_z;
  tao_pkg::coord_t b_x, b_y, b_z;
  tao_pkg::coord_t c_x, c_y, c_z;
  modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, input ready);
  modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, output ready);
endinterface

interface tao_out_if;
  logic valid;
  logic ready;
  logic overlaps;
  modport source (output valid, overlaps, input ready);
  modport sink   (input valid, overlaps, output ready);
endinterface

`default_nettype wire

// File: hdl/tao_front.sv
// stages one and two: relative vertices, edges and the three box axis tests
// depends on tao_pkg
`default_nettype none

module tao_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            in_vld,
  input  wire tao_pkg::coord_t vtx [9],
  input  wire tao_pkg::coord_t box [tao_pkg::NREG],
  output tao_pkg::front_t      f_o
);

  typedef struct packed {
    logic                   vld;
    tao_pkg::v_t [2:0][2:0] v;
    tao_pkg::h_t [2:0]      h;
  } s1_t;

  s1_t             s1_r, s1_nxt;
  tao_pkg::front_t f_r, f_nxt;

  always_comb begin
    s1_nxt.vld = in_vld;
    for (int i = 0; i < 3; i++) begin
      s1_nxt.h[i] = tao_pkg::h_t'(box[3+i]) - tao_pkg::h_t'(box[i]);
      for (int k = 0; k < 3; k++) begin
        s1_nxt.v[k][i] = (tao_pkg::v_t'(vtx[3*k+i]) <<< 1)
                       - (tao_pkg::v_t'(box[i]) + tao_pkg::v_t'(box[3+i]));
      end
    end
  end

  always_comb begin
    f_nxt.vld = s1_r.vld;
    f_nxt.v   = s1_r.v;
    f_nxt.h   = s1_r.h;
    f_nxt.sep = 1'b0;
    for (int i = 0; i < 3; i++) begin
      f_nxt.sep = f_nxt.sep | tao_pkg::sep3(tao_pkg::sw_t'($signed(s1_r.v[0][i])),
                                            tao_pkg::sw_t'($signed(s1_r.v[1][i])),
                                            tao_pkg::sw_t'($signed(s1_r.v[2][i])),
                                            tao_pkg::sw_t'($signed(s1_r.h[i])));
      for (int k = 0; k < 3; k++) begin
        f_nxt.e[k][i] = tao_pkg::e_t'($signed(s1_r.v[(k+1)%3][i]))
                      - tao_pkg::e_t'($signed(s1_r.v[k][i]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.vld <= 1'b0;
      f_r.vld  <= 1'b0;
    end else if (en) begin
      s1_r.vld <= s1_nxt.vld;
      f_r.vld  <= f_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r.v  <= s1_nxt.v;
      s1_r.h  <= s1_nxt.h;
      f_r.sep <= f_nxt.sep;
      f_r.v   <= f_nxt.v;
      f_r.e   <= f_nxt.e;
      f_r.h   <= f_nxt.h;
    end
  end

  assign f_o = f_r;

endmodule

`default_nettype wire

// File: hdl/tao_prod.sv
// stages three and four: normal and edge axis products, then their sums
// depends on tao_pkg
`default_nettype none

module tao_prod (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire tao_pkg::front_t f_i,
  output tao_pkg::prod_t       p_o
);

  localparam int PW  = tao_pkg::PW;
  localparam int NPW = tao_pkg::NPW;
  localparam int RPW = tao_pkg::HW + tao_pkg::EW + 1;
  localparam int EW  = tao_pkg::EW;

  typedef logic signed [NPW-1:0] np_t;
  typedef logic signed [PW-1:0]  pv_t;
  typedef logic signed [RPW-1:0] rp_t;

  typedef struct packed {
    logic                       vld;
    logic                       sep;
    tao_pkg::v_t [2:0]          v0;
    tao_pkg::h_t [2:0]          h;
    np_t [2:0][1:0]             np;
    pv_t [2:0][2:0][2:0][1:0]   pv;
    rp_t [2:0][2:0][1:0]        rp;
  } s3_t;

  s3_t            s3_r, s3_nxt;
  tao_pkg::prod_t p_r, p_nxt;
  logic [EW-1:0]  ae [3][3];

  // edge magnitudes for the radius products
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      for (int i = 0; i < 3; i++) begin
        ae[k][i] = f_i.e[k][i][EW-1] ? (~f_i.e[k][i] + 1'b1) : f_i.e[k][i];
      end
    end
  end

  always_comb begin
    s3_nxt.vld = f_i.vld;
    s3_nxt.sep = f_i.sep;
    s3_nxt.v0  = f_i.v[0];
    s3_nxt.h   = f_i.h;
    for (int i = 0; i < 3; i++) begin
      s3_nxt.np[i][0] = $signed(f_i.e[0][(i+1)%3]) * $signed(f_i.e[1][(i+2)%3]);
      s3_nxt.np[i][1] = $signed(f_i.e[0][(i+2)%3]) * $signed(f_i.e[1][(i+1)%3]);
    end
    // axis e_k x unit_j has e_k[b] at a and -e_k[a] at b
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        for (int m = 0; m < 3; m++) begin
          s3_nxt.pv[k][j][m][0] = $signed(f_i.v[m][(j+1)%3]) * $signed(f_i.e[k][(j+2)%3]);
          s3_nxt.pv[k][j][m][1] = $signed(f_i.v[m][(j+2)%3]) * $signed(f_i.e[k][(j+1)%3]);
        end
        s3_nxt.rp[k][j][0] = $signed(f_i.h[(j+1)%3]) * $signed({1'b0, ae[k][(j+2)%3]});
        s3_nxt.rp[k][j][1] = $signed(f_i.h[(j+2)%3]) * $signed({1'b0, ae[k][(j+1)%3]});
      end
    end
  end

  always_comb begin
    p_nxt.vld = s3_r.vld;
    p_nxt.sep = s3_r.sep;
    p_nxt.v0  = s3_r.v0;
    p_nxt.h   = s3_r.h;
    for (int i = 0; i < 3; i++) begin
      p_nxt.n[i] = tao_pkg::n_t'($signed(s3_r.np[i][0]))
                 - tao_pkg::n_t'($signed(s3_r.np[i][1]));
    end
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        for (int m = 0; m < 3; m++) begin
          p_nxt.pj[k][j][m] = tao_pkg::pj_t'($signed(s3_r.pv[k][j][m][0]))
                            - tao_pkg::pj_t'($signed(s3_r.pv[k][j][m][1]));
        end
        p_nxt.rad[k][j] = tao_pkg::r_t'($signed(s3_r.rp[k][j][0]))
                        + tao_pkg::r_t'($signed(s3_r.rp[k][j][1]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r.vld <= 1'b0;
      p_r.vld  <= 1'b0;
    end else if (en) begin
      s3_r.vld <= s3_nxt.vld;
      p_r.vld  <= p_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r.sep <= s3_nxt.sep;
      s3_r.v0  <= s3_nxt.v0;
      s3_r.h   <= s3_nxt.h;
      s3_r.np  <= s3_nxt.np;
      s3_r.pv  <= s3_nxt.pv;
      s3_r.rp  <= s3_nxt.rp;
      p_r.sep  <= p_nxt.sep;
      p_r.v0   <= p_nxt.v0;
      p_r.h    <= p_nxt.h;
      p_r.n    <= p_nxt.n;
      p_r.pj   <= p_nxt.pj;
      p_r.rad  <= p_nxt.rad;
    end
  end

  assign p_o = p_r;

endmodule

`default_nettype wire

// File: hdl/tao_resolve.sv
// stages five and six: edge axis verdicts and the split normal dot products
// depends on tao_pkg
`default_nettype none

module tao_resolve (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire tao_pkg::prod_t  p_i,
  output logic                 res_vld,
  output logic                 res_ov
);

  localparam int NW  = tao_pkg::NW;
  localparam int NL  = tao_pkg::NL;
  localparam int NH  = tao_pkg::NH;
  localparam int DLW = NL + 1 + tao_pkg::VW;
  localparam int DHW = NH + tao_pkg::VW;
  localparam int RLW = NL + 1 + tao_pkg::HW;
  localparam int RHW = NH + 1 + tao_pkg::HW;

  typedef logic signed [DLW-1:0] dl_t;
  typedef logic signed [DHW-1:0] dh_t;
  typedef logic signed [RLW-1:0] rl_t;
  typedef logic signed [RHW-1:0] rh_t;

  typedef struct packed {
    logic       vld;
    logic       sep;
    dl_t [2:0]  dl;
    dh_t [2:0]  dh;
    rl_t [2:0]  rl;
    rh_t [2:0]  rh;
  } s5_t;

  typedef struct packed {
    logic               vld;
    logic               sep;
    tao_pkg::sw_t [2:0] d;
    tao_pkg::sw_t [2:0] r;
  } s6_t;

  s5_t          s5_r, s5_nxt;
  s6_t          s6_r, s6_nxt;
  logic [NW-1:0] na [3];
  tao_pkg::sw_t dsum, rsum;

  always_comb begin
    s5_nxt.vld = p_i.vld;
    s5_nxt.sep = p_i.sep;
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        s5_nxt.sep = s5_nxt.sep | tao_pkg::sep3(tao_pkg::sw_t'($signed(p_i.pj[k][j][0])),
                                                tao_pkg::sw_t'($signed(p_i.pj[k][j][1])),
                                                tao_pkg::sw_t'($signed(p_i.pj[k][j][2])),
                                                tao_pkg::sw_t'($signed(p_i.rad[k][j])));
      end
    end
    // normal split in halves so each multiply stays narrow
    for (int i = 0; i < 3; i++) begin
      na[i] = p_i.n[i][NW-1] ? (~p_i.n[i] + 1'b1) : p_i.n[i];
      s5_nxt.dl[i] = $signed({1'b0, p_i.n[i][NL-1:0]}) * $signed(p_i.v0[i]);
      s5_nxt.dh[i] = $signed(p_i.n[i][NW-1:NL]) * $signed(p_i.v0[i]);
      s5_nxt.rl[i] = $signed({1'b0, na[i][NL-1:0]}) * $signed(p_i.h[i]);
      s5_nxt.rh[i] = $signed({1'b0, na[i][NW-1:NL]}) * $signed(p_i.h[i]);
    end
  end

  always_comb begin
    s6_nxt.vld = s5_r.vld;
    s6_nxt.sep = s5_r.sep;
    for (int i = 0; i < 3; i++) begin
      s6_nxt.d[i] = (tao_pkg::sw_t'($signed(s5_r.dh[i])) <<< NL)
                  + tao_pkg::sw_t'($signed(s5_r.dl[i]));
      s6_nxt.r[i] = (tao_pkg::sw_t'($signed(s5_r.rh[i])) <<< NL)
                  + tao_pkg::sw_t'($signed(s5_r.rl[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_r.vld <= 1'b0;
      s6_r.vld <= 1'b0;
    end else if (en) begin
      s5_r.vld <= s5_nxt.vld;
      s6_r.vld <= s6_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_r.sep <= s5_nxt.sep;
      s5_r.dl  <= s5_nxt.dl;
      s5_r.dh  <= s5_nxt.dh;
      s5_r.rl  <= s5_nxt.rl;
      s5_r.rh  <= s5_nxt.rh;
      s6_r.sep <= s6_nxt.sep;
      s6_r.d   <= s6_nxt.d;
      s6_r.r   <= s6_nxt.r;
    end
  end

  // normal axis: a single projected point, separated when |d| > radius
  always_comb begin
    dsum    = s6_r.d[0] + s6_r.d[1] + s6_r.d[2];
    rsum    = s6_r.r[0] + s6_r.r[1] + s6_r.r[2];
    res_vld = s6_r.vld;
    res_ov  = !(s6_r.sep || (dsum < -rsum) || (rsum < dsum));
  end

endmodule

`default_nettype wire

// File: hdl/triangle_aabb_overlap_test.sv
// triangle versus box overlap, separating axis test, exact fixed point
// the flag passes through the six register stages and then the output register
// throughput: one triangle per cycle while the output is not stalled
// a stall on the output freezes every stage at once, so nothing is lost or repeated
// reset (rst_n low, synchronous) clears all valid bits and the box corners to zero
`default_nettype none

module triangle_aabb_overlap_test (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  tao_in_if.sink                          in_ch,
  tao_out_if.source                       out_ch,
  input  wire logic                       cfg_we,
  input  wire logic [tao_pkg::IDXW-1:0]   cfg_idx,
  input  wire logic [tao_pkg::CW-1:0]     cfg_wdata
);

  // box corners: min x y z, then max x y z
  tao_pkg::coord_t box_r [tao_pkg::NREG];
  tao_pkg::coord_t vtx   [9];

  tao_pkg::front_t front;
  tao_pkg::prod_t  prod;

  logic en;
  logic res_vld, res_ov;
  logic out_vld_r, out_ov_r;

  // whole pipe advances unless the output register holds an untaken flag
  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // configuration writes, indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < tao_pkg::NREG; i++) box_r[i] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        tao_pkg::REG_MIN_X: box_r[0] <= cfg_wdata;
        tao_pkg::REG_MIN_Y: box_r[1] <= cfg_wdata;
        tao_pkg::REG_MIN_Z: box_r[2] <= cfg_wdata;
        tao_pkg::REG_MAX_X: box_r[3] <= cfg_wdata;
        tao_pkg::REG_MAX_Y: box_r[4] <= cfg_wdata;
        tao_pkg::REG_MAX_Z: box_r[5] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // vertex a, b, c in x y z order
  assign vtx[0] = in_ch.a_x;
  assign vtx[1] = in_ch.a_y;
  assign vtx[2] = in_ch.a_z;
  assign vtx[3] = in_ch.b_x;
  assign vtx[4] = in_ch.b_y;
  assign vtx[5] = in_ch.b_z;
  assign vtx[6] = in_ch.c_x;
  assign vtx[7] = in_ch.c_y;
  assign vtx[8] = in_ch.c_z;

  // stages one and two: doubled relative vertices, edges, box axes
  tao_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .in_vld (in_ch.valid),
    .vtx    (vtx),
    .box    (box_r),
    .f_o    (front)
  );

  // stages three and four: cross products for the normal and for each edge against each unit axis
  tao_prod u_prod (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .f_i   (front),
    .p_o   (prod)
  );

  // stages five and six: edge axis verdicts, normal projection and radius
  tao_resolve u_resolve (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .p_i     (prod),
    .res_vld (res_vld),
    .res_ov  (res_ov)
  );

  // output register, holds the flag until its transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= res_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_ov_r <= res_ov;
    end
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.overlaps = out_ov_r;

endmodule

`default_nettype wire

// File: hdl/tao_check.sv
// port level checks for the triangle versus box overlap block
// depends on triangle_aabb_overlap_test_defines.svh, bound to the top level
`default_nettype none
`include "triangle_aabb_overlap_test_defines.svh"

module tao_check (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic overlaps
);

  `TAO_ASSERT(a_ready_tracks_stall, in_ready == (!out_valid || out_ready))
  `TAO_ASSERT(a_out_held, (out_valid && !out_ready) |=> out_valid)
  `TAO_ASSERT(a_flag_held, (out_valid && !out_ready) |=> $stable(overlaps))
  `TAO_ASSERT_RST(a_reset_empty, !rst_n |=> !out_valid)

endmodule

bind triangle_aabb_overlap_test tao_check u_tao_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .overlaps  (out_ch.overlaps)
);

`default_nettype wire

// File: sim/tao_tb_pkg.sv
// scoreboard class for the triangle versus box overlap testbench
// depends on tao_pkg for coordinate types
package tao_tb_pkg;
  timeunit 1ns;
  timeprecision 1ps;
  import tao_pkg::*;

  typedef logic signed [255:0] big_t;

  typedef struct {
    coord_t x[3];
    coord_t y[3];
    coord_t z[3];
  } tri_t;

  class overlap_scoreboard;
    coord_t box_lo[3];
    coord_t box_hi[3];
    bit flags_due[$];
    int mismatches;
    int checked;
    int hits;

    function void set_corner(int idx, coord_t val);
      if (idx < 3) box_lo[idx] = val;
      else box_hi[idx - 3] = val;
    endfunction

    // interval of three projections strictly outside [-r, r]
    function bit apart(big_t p0, big_t p1, big_t p2, big_t r);
      big_t hi;
      big_t lo;
      hi = p0;
      lo = p0;
      if (p1 > hi) hi = p1;
      if (p2 > hi) hi = p2;
      if (p1 < lo) lo = p1;
      if (p2 < lo) lo = p2;
      return (hi < -r) || (r < lo);
    endfunction

    function big_t mag(big_t a);
      return (a < 0) ? -a : a;
    endfunction

    // doubled coordinates about the box center
    function bit touches(tri_t t);
      big_t v[3][3];
      big_t e[3][3];
      big_t h[3];
      big_t n[3];
      big_t ax[3];
      big_t d;
      big_t rn;
      coord_t p;
      for (int a = 0; a < 3; a++) begin
        h[a] = big_t'(box_hi[a]) - big_t'(box_lo[a]);
        for (int k = 0; k < 3; k++) begin
          p = (a == 0) ? t.x[k] : (a == 1) ? t.y[k] : t.z[k];
          v[k][a] = 2 * big_t'(p) - big_t'(box_lo[a]) - big_t'(box_hi[a]);
        end
      end
      for (int a = 0; a < 3; a++)
        if (apart(v[0][a], v[1][a], v[2][a], h[a])) return 0;
      for (int k = 0; k < 3; k++)
        for (int a = 0; a < 3; a++) e[k][a] = v[(k + 1) % 3][a] - v[k][a];
      n[0] = e[0][1] * e[1][2] - e[0][2] * e[1][1];
      n[1] = e[0][2] * e[1][0] - e[0][0] * e[1][2];
      n[2] = e[0][0] * e[1][1] - e[0][1] * e[1][0];
      d = n[0] * v[0][0] + n[1] * v[0][1] + n[2] * v[0][2];
      rn = h[0] * mag(n[0]) + h[1] * mag(n[1]) + h[2] * mag(n[2]);
      if (apart(d, d, d, rn)) return 0;
      // edge cross unit axis j
      for (int k = 0; k < 3; k++)
        for (int j = 0; j < 3; j++) begin
          ax[0] = (j == 2) ? e[k][1] : (j == 1) ? -e[k][2] : 0;
          ax[1] = (j == 0) ? e[k][2] : (j == 2) ? -e[k][0] : 0;
          ax[2] = (j == 1) ? e[k][0] : (j == 0) ? -e[k][1] : 0;
          if (apart(v[0][0] * ax[0] + v[0][1] * ax[1] + v[0][2] * ax[2],
                    v[1][0] * ax[0] + v[1][1] * ax[1] + v[1][2] * ax[2],
                    v[2][0] * ax[0] + v[2][1] * ax[1] + v[2][2] * ax[2],
                    h[0] * mag(ax[0]) + h[1] * mag(ax[1]) + h[2] * mag(ax[2])))
            return 0;
        end
      return 1;
    endfunction

    function void note_triangle(tri_t t);
      flags_due.push_back(touches(t));
    endfunction

    function void check_flag(logic got);
      bit want;
      if (flags_due.size() == 0) begin
        $error("overlaps: unexpected transfer, actual %0b", got);
        mismatches++;
        return;
      end
      want = flags_due.pop_front();
      checked++;
      if (got === 1'b1) hits++;
      if (got !== want) begin
        $error("overlaps: expected %0b actual %0b", want, got);
        mismatches++;
      end
    endfunction
  endclass
endpackage

// File: sim/tb_triangle_aabb_overlap_test.sv
// top-level testbench for the triangle versus box overlap block
// depends on tao_pkg, tao_ifs, tao_tb_pkg and the block itself
module tb_triangle_aabb_overlap_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tao_pkg::*;
  import tao_tb_pkg::*;

  localparam int RANDOM_TRIS = 1750;
  localparam longint CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 20;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [IDXW-1:0] cfg_idx;
  logic [CW-1:0] cfg_wdata;
  longint cycles;
  bit calm;   // no idling on either side while set

  tao_in_if in_ch ();
  tao_out_if out_ch ();

  triangle_aabb_overlap_test dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  overlap_scoreboard sb;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // timeout guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side: random stalls, every transfer goes to the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_flag(out_ch.overlaps);
    out_ch.ready <= calm || ($urandom_range(99) >= 21);
  end

  // one register write on the config port, the caller drops the enable
  task automatic write_reg(logic [IDXW-1:0] idx, coord_t val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_corner(int'(idx), val);
  endtask

  task automatic set_box(coord_t lx, coord_t ly, coord_t lz,
                         coord_t hx, coord_t hy, coord_t hz);
    write_reg(REG_MIN_X, lx);
    write_reg(REG_MIN_Y, ly);
    write_reg(REG_MIN_Z, lz);
    write_reg(REG_MAX_X, hx);
    write_reg(REG_MAX_Y, hy);
    write_reg(REG_MAX_Z, hz);
    cfg_we <= 1'b0;
  endtask

  // present a triangle, hold it until the transfer, maybe idle first
  task automatic send_tri(tri_t t);
    while (!calm && $urandom_range(99) < 21) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.a_x <= t.x[0]; in_ch.a_y <= t.y[0]; in_ch.a_z <= t.z[0];
    in_ch.b_x <= t.x[1]; in_ch.b_y <= t.y[1]; in_ch.b_z <= t.z[1];
    in_ch.c_x <= t.x[2]; in_ch.c_y <= t.y[2]; in_ch.c_z <= t.z[2];
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_triangle(t);
  endtask

  // wait for every flag, then let the pipe settle before a config write
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.flags_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic coord_t any_coord();
    case ($urandom_range(5))
      0: return coord_t'($urandom());
      1: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return coord_t'($signed($urandom_range(0, 32'h000a0000)) - 32'sh00050000);
    endcase
  endfunction

  // mostly small coordinates near the box, also full range and extreme ones
  function automatic tri_t random_tri();
    tri_t t;
    for (int k = 0; k < 3; k++) begin
      t.x[k] = any_coord();
      t.y[k] = any_coord();
      t.z[k] = any_coord();
    end
    return t;
  endfunction

  function automatic tri_t make_tri(coord_t ax, coord_t ay, coord_t az,
                                    coord_t bx, coord_t by, coord_t bz,
                                    coord_t cx, coord_t cy, coord_t cz);
    tri_t t;
    t.x = '{ax, bx, cx};
    t.y = '{ay, by, cy};
    t.z = '{az, bz, cz};
    return t;
  endfunction

  localparam coord_t ONE = 32'sh00010000;
  localparam coord_t MAXC = 32'sh7fffffff;
  localparam coord_t MINC = 32'sh80000000;

  initial begin
    sb = new();
    cycles = 0;
    calm = 0;
    rst_n = 0;
    cfg_we = 0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_ch.valid = 0;
    {in_ch.a_x, in_ch.a_y, in_ch.a_z} = '0;
    {in_ch.b_x, in_ch.b_y, in_ch.b_z} = '0;
    {in_ch.c_x, in_ch.c_y, in_ch.c_z} = '0;
    out_ch.ready = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset box is a single point at the origin
    send_tri(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_tri(make_tri(-ONE, -ONE, 0, ONE, -ONE, 0, 0, ONE, 0));
    drain();

    // unit box from -1 to 1
    set_box(-ONE, -ONE, -ONE, ONE, ONE, ONE);
    // face touching counts as overlap
    send_tri(make_tri(ONE, 0, 0, 2 * ONE, 0, 0, 2 * ONE, ONE, 0));
    // just off the face
    send_tri(make_tri(ONE + 1, 0, 0, 2 * ONE, 0, 0, 2 * ONE, ONE, 0));
    // triangle slicing through the box
    send_tri(make_tri(-4 * ONE, -ONE, 0, 4 * ONE, -ONE, 0, 0, 4 * ONE, 0));
    // touching the box only at the corner (1, 1, 1)
    send_tri(make_tri(3 * ONE, 0, 0, 0, 3 * ONE, 0, 0, 0, 3 * ONE));
    send_tri(make_tri(ONE, ONE, ONE, 3 * ONE, 0, 0, 0, 3 * ONE, 0));
    // touching the box edge along x = 1, y = 1
    send_tri(make_tri(2 * ONE, 0, -4 * ONE, 0, 2 * ONE, -4 * ONE, 0, 2 * ONE, 4 * ONE));
    // degenerate: all vertices equal, and collinear
    send_tri(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_tri(make_tri(-3 * ONE, 0, 0, 0, 0, 0, 3 * ONE, 0, 0));
    // field extremes
    send_tri(make_tri(MAXC, MAXC, MAXC, MINC, MINC, MINC, MAXC, MINC, MAXC));
    send_tri(make_tri(MINC, MAXC, 0, MAXC, MINC, 0, 0, 0, MAXC));
    drain();

    // largest box
    set_box(MINC, MINC, MINC, MAXC, MAXC, MAXC);
    send_tri(make_tri(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, MAXC));
    send_tri(make_tri(MINC, MINC, MINC, MAXC, MINC, MINC, MINC, MAXC, MAXC));
    drain();

    // inverted box uses the negative half size as is
    set_box(ONE, ONE, ONE, -ONE, -ONE, -ONE);
    send_tri(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    send_tri(make_tri(-4 * ONE, -ONE, 0, 4 * ONE, -ONE, 0, 0, 4 * ONE, 0));
    send_tri(make_tri(MINC, MINC, MINC, MAXC, MAXC, MAXC, MAXC, 0, MINC));
    drain();

    // random phases, each with its own box; the middle one runs without idling
    for (int ph = 0; ph < 7; ph++) begin
      coord_t lo[3];
      coord_t hi[3];
      for (int a = 0; a < 3; a++) begin
        lo[a] = coord_t'($signed($urandom_range(0, 32'h00040000)) - 32'sh00030000);
        hi[a] = lo[a] + coord_t'($urandom_range(0, 32'h00040000));
        if (ph == 5) hi[a] = lo[a] - coord_t'($urandom_range(0, ONE));
        if (ph == 6) begin
          lo[a] = coord_t'($urandom());
          hi[a] = coord_t'($urandom());
        end
      end
      set_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
      calm = (ph == 3);
      for (int i = 0; i < RANDOM_TRIS / 7; i++) send_tri(random_tri());
      calm = 0;
      drain();
    end

    $display("checked %0d overlap flags over 11 box settings, %0d reported overlap",
             sb.checked, sb.hits);
    if (sb.mismatches == 0 && sb.flags_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
